FILE: sv/masked_hanning_smoother_macros.svh
// Assertion macros shared by the smoother RTL.
`ifndef MASKED_HANNING_SMOOTHER_MACROS_SVH
`define MASKED_HANNING_SMOOTHER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define MHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define MHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define MHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: sv/mhs_pkg.sv
package mhs_pkg;

    // Unsigned Q1.16 smoothing weights; every row but the all-invalid one sums to one.
    localparam int unsigned WEIGHT_W = 17;

    localparam logic [WEIGHT_W-1:0] W_ZERO       = 17'd0;
    localparam logic [WEIGHT_W-1:0] W_THIRD      = 17'd21845;
    localparam logic [WEIGHT_W-1:0] W_TWO_THIRDS = 17'd43691;
    localparam logic [WEIGHT_W-1:0] W_QUARTER    = 17'd16384;
    localparam logic [WEIGHT_W-1:0] W_HALF       = 17'd32768;
    localparam logic [WEIGHT_W-1:0] W_ONE        = 17'd65536;

    // Half of one LSB after the 16-bit shift, for round half up.
    localparam int unsigned ROUND_BIAS = 32768;
    localparam int unsigned FRAC_BITS  = 16;

    // Tap positions within a weight row.
    localparam int unsigned TAP_OLDER = 0;
    localparam int unsigned TAP_HELD  = 1;
    localparam int unsigned TAP_NEXT  = 2;

    // Row index is {next valid, held valid, older valid}.
    localparam logic [WEIGHT_W-1:0] WEIGHT_TAB [8][3] = '{
        '{W_ZERO,    W_ZERO,       W_ZERO},
        '{W_ONE,     W_ZERO,       W_ZERO},
        '{W_ZERO,    W_ONE,        W_ZERO},
        '{W_THIRD,   W_TWO_THIRDS, W_ZERO},
        '{W_ZERO,    W_ZERO,       W_ONE},
        '{W_HALF,    W_ZERO,       W_HALF},
        '{W_ZERO,    W_TWO_THIRDS, W_THIRD},
        '{W_QUARTER, W_HALF,       W_QUARTER}
    };

    localparam logic [2:0] CODE_ALL_VALID   = 3'b111;
    localparam logic [2:0] CODE_ALL_INVALID = 3'b000;

    // Result queue: each request can produce up to two results.
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = 3;
    localparam int unsigned RESV_W     = 4;
    localparam int unsigned NRES_W     = 2;

endpackage

FILE: sv/masked_hanning_smoother.sv
// Masked three-tap Hanning smoother.
// Input stream (s_axis_*): one spectrum sample per request, tuser is its valid
// bit and tlast marks the final sample of a spectrum. Output stream (m_axis_*):
// smoothed or passed-through sample, tuser is 1 when weights were applied,
// tlast marks the result of the final sample. Results run one sample behind
// the input, so a request with tlast gives two results (one when it is alone in
// its spectrum) and the first sample of a multi-sample spectrum gives none.
// i_cfg_we / i_cfg_wdata set relaxed mode (smooth only when all three neighbors
// are valid); write it while idle. Throughput: one request per cycle while
// s_axis_tready is high. Each result passes a select stage, a multiply stage
// and a sum-and-round stage that writes an eight-entry result queue, from
// which m_axis_tvalid is raised.
// The queue reserves room for every result in flight; s_axis_tready drops
// when fewer than two slots are unreserved, so a stalled receiver backs up
// into the input without losing results.
// Reset (i_rst_n low, synchronous) empties the queue and pipeline, clears
// relaxed mode and starts a new spectrum.
`include "masked_hanning_smoother_macros.svh"

module masked_hanning_smoother #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // sample
    input  logic                                  s_axis_tuser,  // sample_valid
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // smoothed
    output logic                                  m_axis_tuser,  // result_valid
    output logic                                  m_axis_tlast
);
    import mhs_pkg::*;

    localparam int SW      = SAMPLE_WIDTH;
    localparam int TDW     = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int PW      = SAMPLE_WIDTH + WEIGHT_W + 1;
    localparam int SUMW    = PW + 1;
    localparam int ENTRY_W = SAMPLE_WIDTH + 2;

    // Configuration.
    logic r_relaxed;

    // Spectrum state.
    logic signed [SW-1:0] r_older_sample, r_held_sample;
    logic                 r_older_mask, r_held_mask;
    logic                 r_have_held, r_held_is_first;

    // Stage 1: selected operands.
    logic                 r_s1_vld;
    logic [NRES_W-1:0]    r_s1_cnt;
    logic                 r_s1_apply;
    logic [2:0]           r_s1_code;
    logic signed [SW-1:0] r_s1_a, r_s1_b, r_s1_c, r_s1_x2;
    logic                 r_s1_last_a;

    // Stage 2: weighted products.
    logic                 r_s2_vld;
    logic [NRES_W-1:0]    r_s2_cnt;
    logic                 r_s2_apply;
    logic signed [PW-1:0] r_s2_p0, r_s2_p1, r_s2_p2;
    logic signed [SW-1:0] r_s2_pass, r_s2_x2;
    logic                 r_s2_last_a;

    // Result queue.
    logic [ENTRY_W-1:0]   r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, r_rp;
    logic [RESV_W-1:0]    r_cnt, r_resv;

    logic                 in_acc, out_pop;
    logic signed [SW-1:0] in_x;
    logic [2:0]           in_code;
    logic                 in_apply;
    logic [NRES_W-1:0]    n_nres;
    logic signed [SUMW-1:0] sum;
    logic signed [SW-1:0] smooth_val;
    logic [ENTRY_W-1:0]   entry_a, entry_b;
    logic [ENTRY_W-1:0]   head;
    logic [RESV_W-1:0]    n_resv, n_cnt, push_n;

    assign in_x     = $signed(s_axis_tdata[SW-1:0]);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_pop  = m_axis_tvalid && m_axis_tready;
    assign in_code  = {s_axis_tuser, r_held_mask, r_older_mask};
    assign in_apply = r_relaxed ? (in_code == CODE_ALL_VALID)
                                : (in_code != CODE_ALL_INVALID);

    always_comb begin
        if (!r_have_held) begin
            n_nres = s_axis_tlast ? NRES_W'(1) : NRES_W'(0);
        end else begin
            n_nres = s_axis_tlast ? NRES_W'(2) : NRES_W'(1);
        end
    end

    // Two slots must stay free beyond what is already promised.
    assign s_axis_tready = (r_resv <= RESV_W'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relaxed <= 1'b0;
        end else if (i_cfg_we) begin
            r_relaxed <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older_sample  <= '0;
            r_held_sample   <= '0;
            r_older_mask    <= 1'b0;
            r_held_mask     <= 1'b0;
            r_have_held     <= 1'b0;
            r_held_is_first <= 1'b0;
        end else if (in_acc) begin
            if (!r_have_held) begin
                // A one-sample spectrum leaves the state untouched.
                if (!s_axis_tlast) begin
                    r_held_sample   <= in_x;
                    r_held_mask     <= s_axis_tuser;
                    r_held_is_first <= 1'b1;
                    r_have_held     <= 1'b1;
                end
            end else begin
                r_older_sample  <= r_held_sample;
                r_older_mask    <= r_held_mask;
                r_held_sample   <= in_x;
                r_held_mask     <= s_axis_tuser;
                r_held_is_first <= 1'b0;
                r_have_held     <= !s_axis_tlast;
            end
        end
    end

    // Stage 1: decide what the request produces and latch the operands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_acc && (n_nres != NRES_W'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cnt  <= n_nres;
        r_s1_code <= in_code;
        r_s1_a    <= r_older_sample;
        r_s1_c    <= in_x;
        r_s1_x2   <= in_x;
        if (!r_have_held) begin
            r_s1_apply  <= 1'b0;
            r_s1_b      <= in_x;
            r_s1_last_a <= 1'b1;
        end else begin
            r_s1_apply  <= !r_held_is_first && in_apply;
            r_s1_b      <= r_held_sample;
            r_s1_last_a <= 1'b0;
        end
    end

    // Stage 2: one constant-table multiply per tap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_cnt    <= r_s1_cnt;
        r_s2_apply  <= r_s1_apply;
        r_s2_pass   <= r_s1_b;
        r_s2_x2     <= r_s1_x2;
        r_s2_last_a <= r_s1_last_a;
        r_s2_p0     <= r_s1_a * $signed({1'b0, WEIGHT_TAB[r_s1_code][TAP_OLDER]});
        r_s2_p1     <= r_s1_b * $signed({1'b0, WEIGHT_TAB[r_s1_code][TAP_HELD]});
        r_s2_p2     <= r_s1_c * $signed({1'b0, WEIGHT_TAB[r_s1_code][TAP_NEXT]});
    end

    // Sum, round half up, then drop the fraction; a convex mix stays in range.
    assign sum = SUMW'(r_s2_p0) + SUMW'(r_s2_p1) + SUMW'(r_s2_p2)
               + SUMW'(ROUND_BIAS);
    assign smooth_val = sum[FRAC_BITS +: SW];

    assign entry_a = r_s2_apply ? {r_s2_last_a, 1'b1, smooth_val}
                                : {r_s2_last_a, 1'b0, r_s2_pass};
    assign entry_b = {1'b1, 1'b0, r_s2_x2};

    assign push_n = r_s2_vld ? RESV_W'(r_s2_cnt) : RESV_W'(0);

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_mem[r_wp] <= entry_a;
            if (r_s2_cnt == NRES_W'(2)) begin
                r_mem[r_wp + FIFO_AW'(1)] <= entry_b;
            end
        end
    end

    always_comb begin
        n_resv = r_resv + (in_acc ? RESV_W'(n_nres) : RESV_W'(0))
               - (out_pop ? RESV_W'(1) : RESV_W'(0));
        n_cnt  = r_cnt + push_n - (out_pop ? RESV_W'(1) : RESV_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_resv <= '0;
        end else begin
            r_wp   <= r_wp + push_n[FIFO_AW-1:0];
            r_rp   <= r_rp + (out_pop ? FIFO_AW'(1) : FIFO_AW'(0));
            r_cnt  <= n_cnt;
            r_resv <= n_resv;
        end
    end

    assign head          = r_mem[r_rp];
    assign m_axis_tvalid = (r_cnt != RESV_W'(0));
    assign m_axis_tdata  = TDW'(head[SW-1:0]);
    assign m_axis_tuser  = head[SW];
    assign m_axis_tlast  = head[SW+1];

    `MHS_ASSERT_IMPLY(a_cnt_within_resv, i_clk, i_rst_n, 1'b1, r_cnt <= r_resv,
        "queue holds more results than were reserved")
    `MHS_ASSERT_IMPLY(a_resv_bound, i_clk, i_rst_n, 1'b1,
        r_resv <= RESV_W'(FIFO_DEPTH), "reservation exceeds queue depth")
    `MHS_ASSERT_IMPLY(a_push_reserved, i_clk, i_rst_n, r_s2_vld,
        r_resv >= r_cnt + RESV_W'(r_s2_cnt), "results pushed without reservation")
    `MHS_ASSERT_NEXT(a_held_follows_last, i_clk, i_rst_n, in_acc,
        r_have_held != $past(s_axis_tlast), "held sample state disagrees with end mark")

endmodule

FILE: dv/masked_hanning_smoother_test.sv
`timescale 1ns / 1ps

module masked_hanning_smoother_test;
    import mhs_pkg::*;

    localparam int SW = 24;
    localparam int DW = ((SW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD = 300;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES = 8;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    // Q1.16 weights per mask code {next, held, older}: older, held, next taps.
    localparam longint HANN_W [8][3] = '{
        '{0,     0,     0},
        '{65536, 0,     0},
        '{0,     65536, 0},
        '{21845, 43691, 0},
        '{0,     0,     65536},
        '{32768, 0,     32768},
        '{0,     43691, 21845},
        '{16384, 32768, 16384}
    };

    typedef struct {
        logic signed [SW-1:0] sample;
        bit                   good;
        bit                   eos;
    } t_spectrum_req;

    typedef struct {
        logic signed [SW-1:0] smoothed;
        bit                   result_valid;
        bit                   last_of_spectrum;
    } t_smoothed_point;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_wdata = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;   // sample
    logic          s_axis_tuser = 1'b0; // sample_valid
    logic          s_axis_tlast = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;        // smoothed
    logic          m_axis_tuser;        // result_valid
    logic          m_axis_tlast;

    masked_hanning_smoother #(
        .SAMPLE_WIDTH(SW)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    t_spectrum_req   pending_samples[$];
    t_smoothed_point expected_points[$];

    int cycle_count = 0;
    int requests_offered = 0;
    int requests_taken = 0;
    int points_checked = 0;
    int points_smoothed = 0;
    int spectra_queued = 0;
    int relaxed_phases = 0;
    int mismatch_count = 0;
    int stray_count = 0;

    bit src_idle_on = 1'b0;
    bit snk_idle_on = 1'b0;
    int stall_asked = 0;
    int stall_served = 0;
    int src_gap = 0;
    int snk_gap = 0;
    int hold_left = 0;

    // Predictor state: one sample back (older) and the sample awaiting its
    // right-hand neighbor (held).
    bit                   pr_relaxed = 1'b0;
    logic signed [SW-1:0] pr_older = '0;
    logic signed [SW-1:0] pr_held = '0;
    bit                   pr_older_good = 1'b0;
    bit                   pr_held_good = 1'b0;
    bit                   pr_have_held = 1'b0;
    bit                   pr_held_first = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic t_smoothed_point smooth_held_point(
        input logic signed [SW-1:0] nxt_sample,
        input bit                   nxt_good
    );
        logic [2:0]      code;
        bit              apply;
        longint          acc;
        longint          shifted;
        t_smoothed_point pt;
        code = {nxt_good, pr_held_good, pr_older_good};
        apply = pr_relaxed ? (code == CODE_ALL_VALID) : (code != CODE_ALL_INVALID);
        pt.last_of_spectrum = 1'b0;
        if (!apply) begin
            pt.smoothed = pr_held;
            pt.result_valid = 1'b0;
        end else begin
            acc = HANN_W[code][0] * longint'(pr_older)
                + HANN_W[code][1] * longint'(pr_held)
                + HANN_W[code][2] * longint'(nxt_sample)
                + 32768;
            // Arithmetic shift floors, which with the bias rounds half up.
            shifted = acc >>> 16;
            pt.smoothed = shifted[SW-1:0];
            pt.result_valid = 1'b1;
        end
        return pt;
    endfunction

    task automatic hanning_step(input t_spectrum_req rq);
        t_smoothed_point pt;
        if (!pr_have_held) begin
            if (rq.eos) begin
                pt.smoothed = rq.sample;
                pt.result_valid = 1'b0;
                pt.last_of_spectrum = 1'b1;
                expected_points.insert(expected_points.size(), pt);
            end else begin
                pr_held = rq.sample;
                pr_held_good = rq.good;
                pr_held_first = 1'b1;
                pr_have_held = 1'b1;
            end
            return;
        end
        if (pr_held_first) begin
            pt.smoothed = pr_held;
            pt.result_valid = 1'b0;
            pt.last_of_spectrum = 1'b0;
        end else begin
            pt = smooth_held_point(rq.sample, rq.good);
        end
        expected_points.insert(expected_points.size(), pt);
        pr_older = pr_held;
        pr_older_good = pr_held_good;
        pr_held = rq.sample;
        pr_held_good = rq.good;
        pr_held_first = 1'b0;
        if (rq.eos) begin
            pt.smoothed = rq.sample;
            pt.result_valid = 1'b0;
            pt.last_of_spectrum = 1'b1;
            expected_points.insert(expected_points.size(), pt);
            pr_have_held = 1'b0;
        end
    endtask

    // Sender: presents one request at a time from the pending queue.
    always @(negedge i_clk) begin : source_proc
        t_spectrum_req rq;
        if (i_rst_n && !(s_axis_tvalid && requests_taken != requests_offered)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                rq = pending_samples.pop_front();
                s_axis_tdata <= DW'($unsigned(rq.sample));
                s_axis_tuser <= rq.good;
                s_axis_tlast <= rq.eos;
                s_axis_tvalid <= 1'b1;
                requests_offered++;
                src_gap = src_idle_on ? pick_gap() : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus the occasional long hold-off.
    always @(negedge i_clk) begin : sink_proc
        if (stall_asked != stall_served) begin
            stall_served = stall_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            snk_gap = snk_idle_on ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin : monitor_proc
        t_spectrum_req   rq;
        t_smoothed_point want;
        t_smoothed_point got;
        cycle_count++;
        if (i_rst_n) begin
            if (i_cfg_we)
                pr_relaxed = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                rq.sample = s_axis_tdata[SW-1:0];
                rq.good = s_axis_tuser;
                rq.eos = s_axis_tlast;
                requests_taken++;
                hanning_step(rq);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.smoothed = m_axis_tdata[SW-1:0];
                got.result_valid = m_axis_tuser;
                got.last_of_spectrum = m_axis_tlast;
                if (expected_points.size() == 0) begin
                    stray_count++;
                    if (mismatch_count + stray_count <= REPORT_LIMIT)
                        $display("%0t: result %0d/%0b/%0b with nothing outstanding", $realtime,
                                 got.smoothed, got.result_valid, got.last_of_spectrum);
                end else begin
                    want = expected_points.pop_front();
                    points_checked++;
                    if (got.result_valid)
                        points_smoothed++;
                    if (got.smoothed !== want.smoothed || got.result_valid !== want.result_valid
                            || got.last_of_spectrum !== want.last_of_spectrum) begin
                        mismatch_count++;
                        if (mismatch_count + stray_count <= REPORT_LIMIT)
                            $display("%0t: mismatch, expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     $realtime, want.smoothed, want.result_valid,
                                     want.last_of_spectrum, got.smoothed, got.result_valid,
                                     got.last_of_spectrum);
                    end
                end
            end
        end
    end

    initial begin : watchdog_proc
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 expected_points.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic signed [SW-1:0] pick_sample();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 8)
            return SAMPLE_MAX;
        else if (r < 16)
            return SAMPLE_MIN;
        else if (r < 30) begin
            s = int'($urandom_range(0, 6)) - 3;
            return s[SW-1:0];
        end else begin
            s = $urandom;
            return s[SW-1:0];
        end
    endfunction

    task automatic add_sample(input logic signed [SW-1:0] smp, input bit good, input bit eos);
        t_spectrum_req rq;
        rq.sample = smp;
        rq.good = good;
        rq.eos = eos;
        pending_samples.insert(pending_samples.size(), rq);
        if (eos)
            spectra_queued++;
    endtask

    task automatic write_relaxed(input bit mode);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (mode)
            relaxed_phases++;
    endtask

    // The first request of a multi-sample spectrum leaves no result behind,
    // so the bench keeps clocking for DRAIN_CYCLES after the last result.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_samples.size() != 0 || requests_taken != requests_offered
               || expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus_proc
        bit   walk_mask [11];
        int   phase;
        int   queued;
        int   len;
        int   good_pct;
        int   r;
        bit   mode;
        walk_mask = '{0, 0, 0, 1, 0, 1, 1, 1, 0, 0, 0};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single- and two-sample spectra at the range limits, then
        // a mask walk that visits every neighbor pattern at least once with large and
        // with tiny samples, the latter exposing rounding ties.
        write_relaxed(1'b0);
        add_sample(SAMPLE_MAX, 1'b1, 1'b1);
        add_sample(SAMPLE_MIN, 1'b0, 1'b1);
        add_sample(SAMPLE_MIN, 1'b1, 1'b0);
        add_sample(SAMPLE_MAX, 1'b1, 1'b1);
        for (int i = 0; i < 11; i++)
            add_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX, walk_mask[i], i == 10);
        for (int i = 0; i < 11; i++)
            add_sample(SW'((i % 3 == 0) ? -1 : ((i % 3 == 1) ? 0 : 1)), walk_mask[i],
                       i == 10);
        wait_drained();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            mode = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
            write_relaxed(mode);
            src_idle_on = (phase != 2) && ($urandom_range(0, 3) != 0);
            snk_idle_on = (phase != 2) && ($urandom_range(0, 3) != 0);
            case (phase % 3)
                0: good_pct = 90;
                1: good_pct = 50;
                default: good_pct = 15;
            endcase
            queued = 0;
            while (queued < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    len = 1;
                else if (r < 10)
                    len = 2;
                else if (r < 85)
                    len = $urandom_range(3, 24);
                else
                    len = $urandom_range(25, 64);
                for (int i = 0; i < len; i++)
                    add_sample(pick_sample(), $urandom_range(0, 99) < good_pct, i == len - 1);
                queued += len;
            end
            // Hold the receiver off long enough for the result queue to fill
            // and push back into the input while requests keep coming.
            if (phase == 2 || phase == 6)
                stall_asked++;
            wait_drained();
        end

        $display("checked %0d results (%0d smoothed) from %0d requests over %0d spectra",
                 points_checked, points_smoothed, requests_taken, spectra_queued);
        $display("%0d of %0d settings used relaxed mode, with back-pressure stalls",
                 relaxed_phases, NUM_PHASES + 1);
        if (mismatch_count == 0 && stray_count == 0 && expected_points.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d unexpected results, %0d missing", mismatch_count,
                     stray_count, expected_points.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/mhs_pkg.sv
sv/masked_hanning_smoother.sv
dv/masked_hanning_smoother_test.sv
